// File: hw/rtl/calibrated_compass_heading_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef CALIBRATED_COMPASS_HEADING_UNIT_MACROS_SVH
`define CALIBRATED_COMPASS_HEADING_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CCH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/cch_pkg.sv
package cch_pkg;

	// Sample, offset, heading, bus and index widths
	localparam int SAMPLE_W = 16;
	localparam int SUM_W = SAMPLE_W + 1;
	localparam int HEADING_W = 9;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_INDEX_W = 1;

	// Register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET = 1'd1;

	// CORDIC sizing
	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int TABLE_LEN = 24;
	localparam int TABLE_FRAC = 16;
	localparam int GUARD_BITS = 24;
	localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
	localparam int FRAC = (ANGLE_FRAC_BITS > TABLE_FRAC) ? TABLE_FRAC : ANGLE_FRAC_BITS;
	localparam int STEP_W = $clog2(TABLE_LEN);

	// Vector width: sample sum, guard bits, CORDIC gain and pre-rotation headroom
	localparam int CW = SUM_W + GUARD_BITS + 3;
	// Angle width: up to about +-190 degrees with FRAC fraction bits, plus sign
	localparam int ZW = FRAC + 10;
	localparam int HW = ZW + 1;

	localparam logic signed [ZW-1:0] Z_90 = ZW'(90 << FRAC);
	localparam logic signed [HW-1:0] H_90 = HW'(90 << FRAC);
	localparam logic signed [HW-1:0] H_360 = HW'(360 << FRAC);

	localparam logic [HEADING_W-1:0] HEADING_ZERO_VEC = 9'd270;
	localparam logic [HEADING_W-1:0] MAX_HEADING = 9'd359;

	// atan(2^-i) in degrees, 16 fraction bits
	localparam int ATAN_Q16 [TABLE_LEN] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	localparam int ROUND_SH = TABLE_FRAC - FRAC;
	localparam int ROUND_HALF = (ROUND_SH == 0) ? 0 : (1 << (ROUND_SH - 1));

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero_vec;
	} cch_vec_t;

	// Table angle rounded half up to FRAC fraction bits
	function automatic logic signed [ZW-1:0] atan_angle(input logic [STEP_W-1:0] i);
		int t;
		t = 0;
		if (i < STEP_W'(TABLE_LEN))
			t = ATAN_Q16[i];
		t = (t + ROUND_HALF) >>> ROUND_SH;
		return ZW'(t);
	endfunction

endpackage

// File: hw/rtl/cch_pre.sv
module cch_pre
	import cch_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] x_sample,
	input  logic signed [SAMPLE_W-1:0] y_sample,
	input  logic signed [SAMPLE_W-1:0] x_offset,
	input  logic signed [SAMPLE_W-1:0] y_offset,
	output logic                       out_valid,
	input  logic                       out_ready,
	output cch_vec_t                   out_vec
);

	logic signed [SUM_W-1:0] xs, ys;
	logic signed [CW-1:0] xg, yg;
	cch_vec_t nxt;
	cch_vec_t vec_q;
	logic vld_q;

	assign xs = {x_sample[SAMPLE_W-1], x_sample} + {x_offset[SAMPLE_W-1], x_offset};
	assign ys = {y_sample[SAMPLE_W-1], y_sample} + {y_offset[SAMPLE_W-1], y_offset};
	assign xg = {{(CW-SUM_W){xs[SUM_W-1]}}, xs} <<< GUARD_BITS;
	assign yg = {{(CW-SUM_W){ys[SUM_W-1]}}, ys} <<< GUARD_BITS;

	// Fold the left half-plane into the right one by a quarter turn
	always_comb begin
		nxt.zero_vec = (xs == '0) && (ys == '0);
		nxt.x = xg;
		nxt.y = yg;
		nxt.z = '0;
		if (xs[SUM_W-1]) begin
			if (!ys[SUM_W-1]) begin
				nxt.x = yg;
				nxt.y = -xg;
				nxt.z = Z_90;
			end else begin
				nxt.x = -yg;
				nxt.y = xg;
				nxt.z = -Z_90;
			end
		end
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_vec = vec_q;

endmodule

// File: hw/rtl/cch_cell.sv
module cch_cell
	import cch_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] step,
	input  logic              in_valid,
	output logic              in_ready,
	input  cch_vec_t          in_vec,
	output logic              out_valid,
	input  logic              out_ready,
	output cch_vec_t          out_vec
);

	logic signed [CW-1:0] dx, dy;
	logic signed [ZW-1:0] ang;
	logic rot_neg;
	cch_vec_t nxt;
	cch_vec_t vec_q;
	logic vld_q;

	assign dx = in_vec.y >>> step;
	assign dy = in_vec.x >>> step;
	assign ang = atan_angle(step);
	// Rotate clockwise while y is strictly positive
	assign rot_neg = !in_vec.y[CW-1] && (in_vec.y != '0);

	always_comb begin
		nxt.zero_vec = in_vec.zero_vec;
		if (rot_neg) begin
			nxt.x = in_vec.x + dx;
			nxt.y = in_vec.y - dy;
			nxt.z = in_vec.z + ang;
		end else begin
			nxt.x = in_vec.x - dx;
			nxt.y = in_vec.y + dy;
			nxt.z = in_vec.z - ang;
		end
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign out_vec = vec_q;

endmodule

// File: hw/rtl/cch_post.sv
module cch_post
	import cch_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  cch_vec_t             in_vec,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [HEADING_W-1:0] heading
);

	logic signed [HW-1:0] h0, h1;
	logic [HEADING_W:0] whole;
	logic [HEADING_W-1:0] nxt;
	logic [HEADING_W-1:0] heading_q;
	logic vld_q;

	// Take off the mounting quarter turn and wrap into 0..360
	assign h0 = {in_vec.z[ZW-1], in_vec.z} - H_90;
	always_comb begin
		h1 = h0[HW-1] ? (h0 + H_360) : h0;
		if (h1[HW-1])
			h1 = '0;
	end
	assign whole = h1[FRAC+HEADING_W:FRAC];

	always_comb begin
		if (in_vec.zero_vec)
			nxt = HEADING_ZERO_VEC;
		else if (whole > {1'b0, MAX_HEADING})
			nxt = MAX_HEADING;
		else
			nxt = whole[HEADING_W-1:0];
	end

	assign in_ready = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			heading_q <= nxt;
		end
	end

	assign out_valid = vld_q;
	assign heading = heading_q;

endmodule

// File: hw/rtl/calibrated_compass_heading_unit.sv
// Channel      Dir  Payload (low bit first)                 Handshake
// s_axis       in   x_sample[15:0], y_sample[31:16]           tvalid/tready
// m_axis       out  heading_deg[8:0], zero pad [15:9]         tvalid/tready
// cfg          in   index 0 x_offset, 1 y_offset (16b signed) cfg_we, no wait
//
// One sample pair per cycle while m_axis is not stalled. Stages: one
// offset/pre-rotation stage, one cell per CORDIC step, one output stage.
// Every stage holds its own valid bit, so bubbles close up under a stall and a
// new pair is taken while a finished heading waits on m_axis.
// arst_n clears all valid bits and both offsets to zero.
// Write offsets only while no transfer is in flight.
module calibrated_compass_heading_unit
	import cch_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // x_sample, y_sample
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // heading_deg, zero pad
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [SAMPLE_W-1:0]    cfg_wdata
);

	logic signed [SAMPLE_W-1:0] x_offset_q, y_offset_q;
	logic [HEADING_W-1:0] heading;

	// Stage links: element 0 is the pre-rotation output, element STEPS feeds
	// the output stage.
	cch_vec_t chain_vec [STEPS+1];
	logic chain_vld [STEPS+1];
	logic chain_rdy [STEPS+1];

	// Offset registers; writes land on the clock edge where cfg_we is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q <= '0;
			y_offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_OFFSET: x_offset_q <= cfg_wdata;
				REG_Y_OFFSET: y_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Add calibration, fold the left half-plane, scale up by the guard bits
	cch_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.x_sample  (s_axis_tdata[SAMPLE_W-1:0]),
		.y_sample  (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
		.x_offset  (x_offset_q),
		.y_offset  (y_offset_q),
		.out_valid (chain_vld[0]),
		.out_ready (chain_rdy[0]),
		.out_vec   (chain_vec[0])
	);

	// One vectoring micro-rotation per cell; the step number fixes shift and angle
	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		cch_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (STEP_W'(g)),
			.in_valid  (chain_vld[g]),
			.in_ready  (chain_rdy[g]),
			.in_vec    (chain_vec[g]),
			.out_valid (chain_vld[g+1]),
			.out_ready (chain_rdy[g+1]),
			.out_vec   (chain_vec[g+1])
		);
	end

	// Mounting correction, wrap, truncate to whole degrees
	cch_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_vld[STEPS]),
		.in_ready  (chain_rdy[STEPS]),
		.in_vec    (chain_vec[STEPS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.heading   (heading)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W-HEADING_W){1'b0}}, heading};

endmodule

// File: hw/rtl/cch_checker.sv
`include "calibrated_compass_heading_unit_macros.svh"

module cch_checker
	import cch_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [HEADING_W-1:0] heading;
	logic [OUT_TDATA_W-HEADING_W-1:0] pad;
	logic [OUT_TDATA_W:0] out_view;
	logic in_range;
	logic out_free;
	logic out_stall;

	assign heading = m_axis_tdata[HEADING_W-1:0];
	assign pad = m_axis_tdata[OUT_TDATA_W-1:HEADING_W];
	assign in_range = heading <= MAX_HEADING;
	// A held result keeps tvalid high and tdata unchanged
	assign out_view = {m_axis_tvalid, m_axis_tdata};
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	`CCH_ASSERT_NOW(a_heading_range, clk, arst_n, m_axis_tvalid, in_range, "heading above 359")
	`CCH_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid, pad == '0, "tdata padding not zero")
	`CCH_ASSERT_NOW(a_ready_free, clk, arst_n, out_free, s_axis_tready, "s_axis stalled needlessly")
	`CCH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, $stable(out_view), "result changed")

endmodule

bind calibrated_compass_heading_unit cch_checker u_cch_checker (.*);

// File: tb/calibrated_compass_heading_unit_tb.sv
module calibrated_compass_heading_unit_tb;
	import cch_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	// Pipeline depth is CORDIC_STEPS + 2; leave some margin for the tail.
	localparam int DRAIN_CYCLES = CORDIC_STEPS + 8;
	localparam int LONG_STALL = 300;
	localparam int RANDOM_FIRST = 150;
	localparam int RANDOM_PER_PHASE = 145;
	localparam int OFFSET_PHASES = 6;

	// One sample pair as it travels on s_axis_tdata: x in the low half.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] y;
		logic signed [SAMPLE_W-1:0] x;
	} pair_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // x_sample, y_sample
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // heading_deg, zero pad
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_X_OFFSET;
	logic [SAMPLE_W-1:0]    cfg_wdata = '0;

	// Offsets as the block should hold them right now.
	logic signed [SAMPLE_W-1:0] x_offset_now = '0;
	logic signed [SAMPLE_W-1:0] y_offset_now = '0;

	pair_t samples_to_send[$];
	logic [HEADING_W-1:0] expected_headings[$];

	// Handshakes as seen at the last rising edge.
	logic sample_taken = 1'b0;
	logic heading_taken = 1'b0;

	int mismatches = 0;
	int cycle_count = 0;

	calibrated_compass_heading_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Heading predictor: offset correction, half-plane fold, vectoring CORDIC in
	// fixed-point degrees, then the mounting turn and wrap into 0..359.
	function automatic logic [HEADING_W-1:0] compass_heading(
		input logic signed [SAMPLE_W-1:0] x_raw,
		input logic signed [SAMPLE_W-1:0] y_raw,
		input logic signed [SAMPLE_W-1:0] x_off,
		input logic signed [SAMPLE_W-1:0] y_off
	);
		longint xs, ys, x, y, z, t, dx, dy, a, h;
		int f, steps, sh, i;
		f = (ANGLE_FRAC_BITS > TABLE_FRAC) ? TABLE_FRAC : ANGLE_FRAC_BITS;
		steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
		sh = TABLE_FRAC - f;
		xs = longint'(x_raw) + longint'(x_off);
		ys = longint'(y_raw) + longint'(y_off);
		if (xs == 0 && ys == 0)
			return HEADING_ZERO_VEC;
		x = xs * (longint'(1) << GUARD_BITS);
		y = ys * (longint'(1) << GUARD_BITS);
		z = 0;
		// Fold the left half-plane into the right one by a quarter turn.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = longint'(90) << f;
			end else begin
				x = -y;
				y = t;
				z = -(longint'(90) << f);
			end
		end
		for (i = 0; i < steps; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			a = ATAN_Q16[i];
			if (sh > 0)
				a = (a + (longint'(1) << (sh - 1))) >>> sh;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += a;
			end else begin
				x -= dx;
				y += dy;
				z -= a;
			end
		end
		h = z - (longint'(90) << f);
		if (h < 0)
			h += longint'(360) << f;
		if (h < 0)
			h = 0;
		h = h >>> f;
		if (h > MAX_HEADING)
			h = MAX_HEADING;
		return HEADING_W'(h);
	endfunction

	// Wait before the next transfer: mostly a random gap, now and then a
	// stretch of back-to-back transfers.
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	function automatic pair_t make_pair(input int x, input int y);
		pair_t p;
		p.x = SAMPLE_W'(x);
		p.y = SAMPLE_W'(y);
		return p;
	endfunction

	// Pair that lands at (dx, dy) once the current offsets are added; wraps
	// where the offset sits at the end of the range.
	function automatic pair_t near_origin(input int dx, input int dy);
		return make_pair(dx - int'(x_offset_now), dy - int'(y_offset_now));
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int corner[4];
		corner = '{-32768, 32767, 0, -1};
		case ($urandom_range(0, 9))
			0, 1: p = near_origin(int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 8)) - 4);
			2: begin
				// Land on one of the corrected axes.
				p = $urandom;
				if ($urandom_range(0, 1) == 0)
					p.x = SAMPLE_W'(-int'(x_offset_now));
				else
					p.y = SAMPLE_W'(-int'(y_offset_now));
			end
			3: p = make_pair(corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)]);
			default: p = $urandom;
		endcase
		return p;
	endfunction

	task automatic write_offset(input logic [CFG_INDEX_W-1:0] idx,
			input logic signed [SAMPLE_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == REG_X_OFFSET)
			x_offset_now = value;
		else
			y_offset_now = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every queued pair went in and every heading came out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || s_axis_tvalid || expected_headings.size() != 0);
	endtask

	// Record both handshakes, predict each accepted pair and check each heading
	// against the oldest prediction.
	always @(posedge clk) begin
		sample_taken <= s_axis_tvalid && s_axis_tready;
		heading_taken <= m_axis_tvalid && m_axis_tready;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_headings.push_back(compass_heading(s_axis_tdata[SAMPLE_W-1:0],
					s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W], x_offset_now, y_offset_now));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_headings.size() == 0) begin
					$error("heading_deg: expected none, got %0d", m_axis_tdata[HEADING_W-1:0]);
					mismatches++;
				end else if (m_axis_tdata[HEADING_W-1:0] != expected_headings[0]) begin
					$error("heading_deg: expected %0d, got %0d", expected_headings[0],
						m_axis_tdata[HEADING_W-1:0]);
					mismatches++;
					void'(expected_headings.pop_front());
				end else begin
					void'(expected_headings.pop_front());
				end
			end
		end
	end

	// Sender: offer queued pairs with a drawn gap ahead of each one; keep
	// tvalid up until the transfer happens.
	logic offering = 1'b0;
	pair_t offered = '0;
	int tx_gap = 0;
	int tx_burst = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (offering && sample_taken)
				offering = 1'b0;
			if (!offering && samples_to_send.size() != 0) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else begin
					offered = samples_to_send.pop_front();
					offering = 1'b1;
					tx_gap = draw_wait(tx_burst);
				end
			end
			s_axis_tvalid <= offering;
			s_axis_tdata <= offered;
		end
	end

	// Receiver: after each transfer drop tready for a drawn number of cycles.
	// Twice hold off for a long stretch so the pipeline fills and stalls s_axis.
	int rx_wait = 0;
	int rx_burst = 0;
	int rx_count = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (heading_taken) begin
				rx_count++;
				if (rx_count == 250 || rx_count == 700)
					rx_wait = LONG_STALL;
				else
					rx_wait = draw_wait(rx_burst);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_axis_tready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("calibrated_compass_heading_unit_tb failed");
			$finish;
		end
	end

	initial begin
		int dir_x[20];
		int dir_y[20];
		logic signed [SAMPLE_W-1:0] nx, ny;
		dir_x = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1,
			0, -1, 0, -1, -1, 1, -1, 32767, -32768, -12345};
		dir_y = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 0,
			1, 0, -1, 1, -1, 32767, 32767, -1, -1, 23456};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset offsets: axes, corners, the zero vector, near the wrap at north.
		for (int i = 0; i < 20; i++)
			samples_to_send.push_back(make_pair(dir_x[i], dir_y[i]));
		for (int i = 0; i < RANDOM_FIRST; i++)
			samples_to_send.push_back(random_pair());
		wait_drained();

		// Walk through offset settings: both extremes, mixed extremes, one wide
		// random setting and one small one.
		for (int p = 0; p < OFFSET_PHASES; p++) begin
			case (p)
				0: begin
					nx = 16'sh8000;
					ny = 16'sh8000;
				end
				1: begin
					nx = 16'sh7fff;
					ny = 16'sh7fff;
				end
				2: begin
					nx = 16'sh7fff;
					ny = 16'sh8000;
				end
				3: begin
					nx = 16'sh8000;
					ny = 16'sh7fff;
				end
				4: begin
					nx = SAMPLE_W'($urandom);
					ny = SAMPLE_W'($urandom);
				end
				default: begin
					nx = SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
					ny = SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
				end
			endcase
			write_offset(REG_X_OFFSET, nx);
			write_offset(REG_Y_OFFSET, ny);
			// Cancel the offsets exactly, then land on the negative X axis, just
			// below the origin and at (-5, -3).
			samples_to_send.push_back(near_origin(0, 0));
			samples_to_send.push_back(near_origin(-1, 0));
			samples_to_send.push_back(near_origin(0, -1));
			samples_to_send.push_back(near_origin(-5, -3));
			for (int i = 0; i < RANDOM_PER_PHASE; i++)
				samples_to_send.push_back(random_pair());
			wait_drained();
		end

		// Catch any stray heading that trails the last one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_headings.size() == 0)
			$display("calibrated_compass_heading_unit_tb passed");
		else
			$display("calibrated_compass_heading_unit_tb failed");
		$finish;
	end

endmodule
